FILE: rtl/substring_match_detector_unit_macros.svh
// Assertion macros used by the checker of the substring match detector
`ifndef SUBSTRING_MATCH_DETECTOR_UNIT_MACROS_SVH
`define SUBSTRING_MATCH_DETECTOR_UNIT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define SMD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the cycle after the antecedent, outside reset
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/smd_pkg.sv
// Package: sizes, cell link and control types of the substring match detector
`timescale 1ns / 1ps
package smd_pkg;

	localparam int MaxPattern = 32;

	typedef logic [7:0] byte_t;

	typedef enum logic {
		OP_PATTERN = 1'b0,
		OP_TEXT    = 1'b1
	} op_t;

	// Data handed from one cell to the next
	typedef struct packed {
		byte_t win;   // text byte
		byte_t pat;   // pattern byte
		logic  act;   // cell lies inside the stored pattern
		logic  seen;  // cell holds a byte of the current text
	} link_t;

	// Row-wide control, shared by every cell
	typedef struct packed {
		logic txt_shift;
		logic txt_clr;
		logic pat_load;
	} cell_ctl_t;

endpackage

FILE: rtl/smd_in_if.sv
// Input channel: pattern and text bytes
`timescale 1ns / 1ps
interface smd_in_if;
	logic            valid;
	logic            ready;
	logic            opcode;
	smd_pkg::byte_t  symbol;
	logic            last;

	modport source (output valid, output opcode, output symbol, output last, input ready);
	modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

FILE: rtl/smd_out_if.sv
// Output channel: search result
`timescale 1ns / 1ps
interface smd_out_if;
	logic valid;
	logic ready;
	logic found;
	logic pattern_overflow;

	modport source (output valid, output found, output pattern_overflow, input ready);
	modport sink   (input valid, input found, input pattern_overflow, output ready);
endinterface

FILE: rtl/smd_cell.sv
// One cell of the compare row: text byte, pattern byte and their compare
`timescale 1ns / 1ps
module smd_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  smd_pkg::cell_ctl_t ctl,
	input  smd_pkg::link_t     link_in,
	output smd_pkg::link_t     link_out,
	output logic               hit
);

	smd_pkg::byte_t win_q;
	smd_pkg::byte_t pat_q;
	logic           act_q;
	logic           seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			seen_q <= 1'b0;
		end else begin
			if (ctl.pat_load) begin
				act_q <= link_in.act;
			end
			if (ctl.txt_clr) begin
				seen_q <= 1'b0;
			end else if (ctl.txt_shift) begin
				seen_q <= link_in.seen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.txt_shift) begin
			win_q <= link_in.win;
		end
		if (ctl.pat_load) begin
			pat_q <= link_in.pat;
		end
	end

	// Compare against the byte that moves in on this shift
	assign hit = !act_q || (link_in.seen && (link_in.win == pat_q));

	assign link_out = '{win: win_q, pat: pat_q, act: act_q, seen: seen_q};

endmodule

FILE: rtl/substring_match_detector_unit.sv
// Top level of the substring match detector: cell row, result stage and output register
//
//  channel | dir | word                              | result
//  --------+-----+-----------------------------------+------------------------------
//  in_ch   | in  | opcode, symbol, last              | pattern byte or text byte
//  out_ch  | out | found, pattern_overflow           | one word per last text byte
//
// One byte is taken in every cycle unless in_ch stalls; every cell compares its byte in the cycle
// the byte arrives, and an AND over the registered row hits gives the verdict.
// A result passes from its last text byte through the registered row hits and the
// output register to out_ch.
// Reset clears the pattern length, the text progress and the status flags; the bytes held in
// the cells are not cleared. in_ch stalls only while a finished result waits in the
// output register and the next result stands behind it.
`timescale 1ns / 1ps
module substring_match_detector_unit (
	input  logic              clk,
	input  logic              arst_n,
	smd_in_if.sink            in_ch,
	smd_out_if.source         out_ch
);

	smd_pkg::link_t               link_in  [smd_pkg::MaxPattern];
	smd_pkg::link_t               link_out [smd_pkg::MaxPattern];
	logic [smd_pkg::MaxPattern-1:0] hit;
	smd_pkg::cell_ctl_t           ctl;

	logic accept;
	logic is_text;
	logic restart;
	logic full;

	logic complete_q;
	logic ovf_q;
	logic match_seen_q;

	logic                           valid_s1;
	logic                           last_s1;
	logic                           nonempty_s1;
	logic                           ovf_s1;
	logic [smd_pkg::MaxPattern-1:0] hits_s1;

	logic out_valid_q;
	logic found_q;
	logic out_ovf_q;

	logic out_free;
	logic s1_adv;
	logic match;

	assign out_free = !out_valid_q || out_ch.ready;
	assign s1_adv   = !valid_s1 || !last_s1 || out_free;

	assign in_ch.ready = s1_adv;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_text     = (in_ch.opcode == smd_pkg::OP_TEXT);

	// A pattern byte after a finished pattern starts a new one
	assign restart = accept && !is_text && complete_q;
	assign full    = link_out[smd_pkg::MaxPattern-1].act && !restart;

	assign ctl.pat_load  = accept && !is_text && !full;
	assign ctl.txt_shift = accept && is_text;
	assign ctl.txt_clr   = restart || (accept && is_text && in_ch.last);

	for (genvar k = 0; k < smd_pkg::MaxPattern; k++) begin : g_cell
		if (k == 0) begin : g_head
			assign link_in[k] = '{win: in_ch.symbol, pat: in_ch.symbol,
				act: 1'b1, seen: 1'b1};
		end else begin : g_body
			// Drop the old pattern extent on restart
			assign link_in[k] = '{win: link_out[k-1].win, pat: link_out[k-1].pat,
				act: link_out[k-1].act && !restart, seen: link_out[k-1].seen};
		end

		smd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.link_in  (link_in[k]),
			.link_out (link_out[k]),
			.hit      (hit[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complete_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			if (is_text) begin
				complete_q <= 1'b1;
			end else begin
				complete_q <= in_ch.last;
				ovf_q      <= (restart ? 1'b0 : ovf_q) || full;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= ctl.txt_shift;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.txt_shift) begin
			last_s1     <= in_ch.last;
			nonempty_s1 <= link_out[0].act;
			ovf_s1      <= ovf_q;
			hits_s1     <= hit;
		end
	end

	assign match = nonempty_s1 && (&hits_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_seen_q <= 1'b0;
		end else if (restart) begin
			match_seen_q <= 1'b0;
		end else if (valid_s1 && s1_adv) begin
			match_seen_q <= last_s1 ? 1'b0 : (match_seen_q || match);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && out_free) begin
			found_q   <= match_seen_q || match;
			out_ovf_q <= ovf_s1;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.found            = found_q;
	assign out_ch.pattern_overflow = out_ovf_q;

endmodule

FILE: rtl/smd_checker.sv
// Port checker for the substring match detector, bound to the top level
`timescale 1ns / 1ps
`include "substring_match_detector_unit_macros.svh"
module smd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_opcode,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_found,
	input logic out_overflow
);

	`SMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_overflow), "result word changed while stalled")

	`SMD_ASSERT_IMP(a_rise_src, $rose(out_valid), $past(in_valid && in_ready && in_opcode && in_last, 2), "result without a last text byte two cycles earlier")

	`SMD_ASSERT_IMP(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled with no result waiting")

endmodule

bind substring_match_detector_unit smd_checker u_smd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_opcode    (in_ch.opcode),
	.in_last      (in_ch.last),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_found    (out_ch.found),
	.out_overflow (out_ch.pattern_overflow)
);

FILE: tb/sv/tb_top.sv
// Testbench top: streams pattern and text bytes and checks every search verdict
`timescale 1ns / 1ps
module tb_top;

	localparam int HALF_PERIOD  = 1;
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_LIMIT   = 1000;
	localparam int ITEMS_TARGET = 1750;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic found;
		logic overflow;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	smd_in_if  in_ch ();
	smd_out_if out_ch ();

	substring_match_detector_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Search state mirrored from the accepted words
	smd_pkg::byte_t pat_mem [smd_pkg::MaxPattern] = '{default: 8'h00};
	smd_pkg::byte_t win_mem [smd_pkg::MaxPattern] = '{default: 8'h00};
	int unsigned pat_len     = 0;
	int unsigned win_fill    = 0;
	bit          pat_closed  = 1'b0;
	bit          pat_dropped = 1'b0;
	bit          hit_seen    = 1'b0;

	verdict_t due_verdicts [$];
	int       fail_count = 0;
	int       items_sent = 0;
	int       idle_cycles = 0;
	bit       calm = 1'b0;

	function automatic void clear_window();
		foreach (win_mem[i])
			win_mem[i] = 8'h00;
		win_fill = 0;
		hit_seen = 1'b0;
	endfunction

	function automatic void predict_search(smd_pkg::op_t op, smd_pkg::byte_t sym, logic lst);
		verdict_t v;
		bit       same;
		if (op == smd_pkg::OP_PATTERN) begin
			if (pat_closed) begin
				pat_len     = 0;
				pat_dropped = 1'b0;
				pat_closed  = 1'b0;
				clear_window();
			end
			if (pat_len < smd_pkg::MaxPattern) begin
				pat_mem[pat_len] = sym;
				pat_len++;
			end else begin
				pat_dropped = 1'b1;
			end
			if (lst)
				pat_closed = 1'b1;
		end else begin
			pat_closed = 1'b1;
			for (int i = smd_pkg::MaxPattern - 1; i > 0; i--)
				win_mem[i] = win_mem[i - 1];
			win_mem[0] = sym;
			if (win_fill < smd_pkg::MaxPattern)
				win_fill++;
			// newest window byte lines up with the last pattern byte
			if (pat_len != 0 && win_fill >= pat_len) begin
				same = 1'b1;
				for (int k = 0; k < pat_len; k++)
					if (win_mem[k] != pat_mem[pat_len - 1 - k])
						same = 1'b0;
				if (same)
					hit_seen = 1'b1;
			end
			if (lst) begin
				v.found    = hit_seen;
				v.overflow = pat_dropped;
				due_verdicts.push_back(v);
				clear_window();
			end
		end
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(smd_pkg::op_t op, smd_pkg::byte_t sym, logic lst);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.opcode <= op;
		in_ch.symbol <= sym;
		in_ch.last   <= lst;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predict_search(op, sym, lst);
		items_sent++;
	endtask

	task automatic send_pattern(smd_pkg::byte_t bytes [$], bit close);
		foreach (bytes[i])
			send_word(smd_pkg::OP_PATTERN, bytes[i], close && i == bytes.size() - 1);
	endtask

	task automatic send_text(smd_pkg::byte_t bytes [$]);
		foreach (bytes[i])
			send_word(smd_pkg::OP_TEXT, bytes[i], i == bytes.size() - 1);
	endtask

	// Hold the input idle until every verdict has come out
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (due_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_pattern();
		send_text('{8'h00, 8'hFF});
	endtask

	task automatic test_symbol_extremes();
		send_pattern('{8'h00, 8'hFF}, 1'b1);
		send_text('{8'hFF, 8'h00, 8'hFF});
	endtask

	task automatic test_text_end_keeps_pattern();
		send_text('{8'h00});
		send_text('{8'h00, 8'hFF});
	endtask

	task automatic test_text_before_pattern_end();
		send_pattern('{8'h5A}, 1'b0);
		send_text('{8'h5A});
		// text closed the pattern, so this byte starts a new one
		send_pattern('{8'hA5}, 1'b1);
		send_text('{8'hA5});
	endtask

	task automatic test_new_pattern_mid_text();
		send_pattern('{8'h11, 8'h22}, 1'b1);
		send_word(smd_pkg::OP_TEXT, 8'h11, 1'b0);
		send_pattern('{8'h33}, 1'b1);
		send_text('{8'h22});
		send_text('{8'h33});
	endtask

	task automatic test_pattern_limits();
		int             lens [5] = '{31, 32, 33, 40, 3};
		smd_pkg::byte_t pat [$];
		smd_pkg::byte_t txt [$];
		int             eff;
		foreach (lens[n]) begin
			pat.delete();
			repeat (lens[n])
				pat.push_back(smd_pkg::byte_t'($urandom));
			send_pattern(pat, 1'b1);
			eff = (lens[n] > smd_pkg::MaxPattern) ? smd_pkg::MaxPattern : lens[n];
			txt.delete();
			repeat ($urandom_range(0, 5))
				txt.push_back(smd_pkg::byte_t'($urandom));
			for (int k = 0; k < eff; k++)
				txt.push_back(pat[k]);
			repeat ($urandom_range(0, 3))
				txt.push_back(smd_pkg::byte_t'($urandom));
			send_text(txt);
			// one byte short of a full alignment
			txt.delete();
			for (int k = 1; k < eff; k++)
				txt.push_back(pat[k]);
			if (txt.size() != 0)
				send_text(txt);
		end
	endtask

	task automatic test_random_sessions();
		smd_pkg::byte_t alpha [4];
		smd_pkg::byte_t pat [$];
		smd_pkg::byte_t txt [$];
		int             n_alpha, plen, eff, tlen, pos, r, next_drain;
		next_drain = items_sent + 300;
		while (items_sent < ITEMS_TARGET) begin
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) begin
				// small alphabet so that matches come often
				n_alpha = $urandom_range(1, 4);
				foreach (alpha[i])
					alpha[i] = smd_pkg::byte_t'($urandom);
				r = $urandom_range(0, 99);
				plen = (r < 70) ? $urandom_range(1, 6) :
					(r < 95) ? $urandom_range(7, 32) : $urandom_range(33, 40);
				eff = (plen > smd_pkg::MaxPattern) ? smd_pkg::MaxPattern : plen;
				pat.delete();
				repeat (plen)
					pat.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
				send_pattern(pat, 1'b1);
				repeat ($urandom_range(1, 3)) begin
					tlen = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 16) :
						$urandom_range(17, 48);
					txt.delete();
					repeat (tlen)
						txt.push_back(alpha[$urandom_range(0, n_alpha - 1)]);
					if ($urandom_range(0, 1) != 0 && tlen >= eff) begin
						pos = $urandom_range(0, tlen - eff);
						for (int k = 0; k < eff; k++)
							txt[pos + k] = pat[k];
					end
					send_text(txt);
				end
			end else begin
				// broken sequences: mixed bytes with stray last marks
				repeat ($urandom_range(1, 10))
					send_word(($urandom_range(0, 1) != 0) ? smd_pkg::OP_TEXT :
						smd_pkg::OP_PATTERN, smd_pkg::byte_t'($urandom),
						$urandom_range(0, 3) == 0);
			end
			if (items_sent >= next_drain) begin
				drain();
				next_drain = items_sent + 300;
			end
		end
		calm = 1'b0;
	endtask

	// Result side: random stalls, mostly short
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			r = $urandom_range(0, 99);
			if (stall_left == 0 && !calm && r < 20)
				stall_left = (r < 3) ? $urandom_range(8, 30) : $urandom_range(1, 3);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (due_verdicts.size() == 0) begin
				note_failure($sformatf("verdict with none pending: found=%0b overflow=%0b",
					out_ch.found, out_ch.pattern_overflow));
			end else begin
				want = due_verdicts.pop_front();
				if (out_ch.found !== want.found || out_ch.pattern_overflow !== want.overflow)
					note_failure($sformatf({"verdict mismatch: expected found=%0b ",
						"overflow=%0b, got found=%0b overflow=%0b"}, want.found,
						want.overflow, out_ch.found, out_ch.pattern_overflow));
			end
		end
	end

	// Watchdog: end the run when no word moves for too long
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.opcode <= smd_pkg::OP_PATTERN;
		in_ch.symbol <= 8'h00;
		in_ch.last   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_pattern();
		test_symbol_extremes();
		test_text_end_keeps_pattern();
		test_text_before_pattern_end();
		test_new_pattern_mid_text();
		drain();
		test_pattern_limits();
		test_random_sessions();

		drain();
		repeat (10) @(posedge clk);
		if (due_verdicts.size() != 0)
			note_failure($sformatf("%0d verdicts never arrived", due_verdicts.size()));
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
